@@ hdl/site_ban_substring_match_macros.svh @@
// Assertion macros for the banned-site substring matcher.
// Used by site_ban_substring_match.sv; depends on its clock and reset ports.
`ifndef SITE_BAN_SUBSTRING_MATCH_MACROS_SVH
`define SITE_BAN_SUBSTRING_MATCH_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SBSM_CHECK_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("site_ban_substring_match: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define SBSM_CHECK_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("site_ban_substring_match: next-cycle check failed");

`endif

@@ hdl/sbsm_pkg.sv @@
// Shared types, sizes and helpers for the banned-site substring matcher.
// No dependencies.
`timescale 1ns / 1ps

package sbsm_pkg;

   // Table geometry.
   localparam int SLOT_COUNT  = 16;
   localparam int PATTERN_MAX = 32;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int POS_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

   // Fixed field widths.
   localparam int CMD_W   = 2;
   localparam int SLOTF_W = 4;
   localparam int POSF_W  = 5;
   localparam int LENF_W  = 6;
   localparam int LVL_W   = 2;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_BYTE = 2'd0,
      CMD_SET_SLOT   = 2'd1,
      CMD_HOST_BYTE  = 2'd2
   } cmd_type;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_TAIL = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   // Fold ASCII upper case letters to lower case.
   function automatic logic [7:0] fold_lower(input logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         c = b + 8'h20;
      end
      return c;
   endfunction

endpackage

@@ hdl/site_ban_substring_match.sv @@
// Pattern byte and slot commands complete in the accept cycle.
// A hostname byte keeps the block busy through the scan state, which reads one
// pattern-memory row per slot, and the tail state; on the last byte the hold
// state then loads the result once the result register is free. No new byte is
// accepted until the block is back in idle, so a stalled result holds off the input.
// Reset (synchronous, active high) clears all slots to unused and clears
// match state; pattern bytes are undefined until written.
`timescale 1ns / 1ps

module site_ban_substring_match (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sbsm_pkg::CMD_W-1:0]   req_cmd,
   input  logic [sbsm_pkg::SLOTF_W-1:0] req_slot,
   input  logic [sbsm_pkg::POSF_W-1:0]  req_position,
   input  logic [7:0]                   req_data_byte,
   input  logic [sbsm_pkg::LENF_W-1:0]  req_pattern_length,
   input  logic [sbsm_pkg::LVL_W-1:0]   req_ban_level,
   input  logic                         req_last_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sbsm_pkg::LVL_W-1:0]   rsp_host_ban_level
);
   import sbsm_pkg::*;

   // Pattern memory: one row per slot, byte-wide writes, whole-row reads.
   logic [7:0] pat_mem [SLOT_COUNT][PATTERN_MAX];
   logic [7:0] row_ff [PATTERN_MAX];

   // Per-slot state.
   logic [LEN_W-1:0]       len_ff [SLOT_COUNT];
   logic [LVL_W-1:0]       lvl_ff [SLOT_COUNT];
   logic [PATTERN_MAX-1:0] pm_ff  [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  hit_ff;

   // Sequencer and datapath registers.
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              proc_valid_ff, proc_valid_in;
   logic [SLOT_W-1:0] proc_slot_ff;
   logic [7:0]        char_ff;
   logic              last_ff;
   logic [LVL_W-1:0]  best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0]  rsp_level_ff;

   // Shared compare unit signals.
   logic                   req_xfer;
   logic                   host_start;
   logic                   scan_end;
   logic                   load_rsp;
   logic [LEN_W-1:0]       cur_len;
   logic [PATTERN_MAX-1:0] eq_vec;
   logic [PATTERN_MAX-1:0] pm_new;
   logic                   hit_new;
   logic [LEN_W-1:0]       sat_len;
   logic [SLOT_W-1:0]      wr_slot;
   logic [POS_W-1:0]       wr_pos;

   assign req_ready          = (state_ff == ST_IDLE);
   assign req_xfer           = req_valid && req_ready;
   assign host_start         = req_xfer && (req_cmd == CMD_HOST_BYTE);
   assign scan_end           = (cnt_ff == SLOT_W'(SLOT_COUNT - 1));
   assign load_rsp           = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_host_ban_level = rsp_level_ff;
   assign wr_slot            = SLOT_W'(req_slot);
   assign wr_pos             = POS_W'(req_position);

   // Lengths above the row size saturate.
   assign sat_len = (LEN_W'(req_pattern_length) > LEN_W'(PATTERN_MAX)) ?
                    LEN_W'(PATTERN_MAX) : LEN_W'(req_pattern_length);

   // Pattern memory write port and registered row read.
   always_ff @(posedge clock) begin
      if (req_xfer && (req_cmd == CMD_WRITE_BYTE)) begin
         pat_mem[wr_slot][wr_pos] <= fold_lower(req_data_byte);
      end
      row_ff <= pat_mem[cnt_ff];
   end

   // Compare the hostname byte against one slot row and step its shift-and vector.
   always_comb begin
      cur_len = len_ff[proc_slot_ff];
      for (int j = 0; j < PATTERN_MAX; j++) begin
         eq_vec[j] = (row_ff[j] == char_ff) && (LEN_W'(j) < cur_len);
      end
      pm_new  = ((pm_ff[proc_slot_ff] << 1) | PATTERN_MAX'(1)) & eq_vec;
      hit_new = (cur_len != '0) && pm_new[POS_W'(cur_len - LEN_W'(1))];
   end

   // Running maximum of ban levels over hit slots.
   always_comb begin
      best_in = best_ff;
      if (host_start) begin
         best_in = '0;
      end else if (proc_valid_ff && (cur_len != '0) &&
                   (hit_ff[proc_slot_ff] || hit_new) &&
                   (lvl_ff[proc_slot_ff] > best_ff)) begin
         best_in = lvl_ff[proc_slot_ff];
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      proc_valid_in = (state_ff == ST_SCAN);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (host_start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + SLOT_W'(1);
            if (scan_end) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            cnt_in   = '0;
            state_in = last_ff ? ST_HOLD : ST_IDLE;
         end
         ST_HOLD: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         proc_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         proc_valid_ff <= proc_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      proc_slot_ff <= cnt_ff;
      best_ff      <= best_in;
      if (host_start) begin
         char_ff <= fold_lower(req_data_byte);
         last_ff <= req_last_byte;
      end
      if (load_rsp) begin
         rsp_level_ff <= best_ff;
      end
   end

   // Slot table and match state: set on slot commands, stepped per scan,
   // cleared after the last hostname byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            len_ff[s] <= '0;
            lvl_ff[s] <= '0;
            pm_ff[s]  <= '0;
         end
         hit_ff <= '0;
      end else if (req_xfer && (req_cmd == CMD_SET_SLOT)) begin
         len_ff[wr_slot]  <= sat_len;
         lvl_ff[wr_slot]  <= req_ban_level;
         pm_ff[wr_slot]   <= '0;
         hit_ff[wr_slot]  <= 1'b0;
      end else if ((state_ff == ST_TAIL) && last_ff) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            pm_ff[s] <= '0;
         end
         hit_ff <= '0;
      end else if (proc_valid_ff && (cur_len != '0)) begin
         pm_ff[proc_slot_ff] <= pm_new;
         if (hit_new) begin
            hit_ff[proc_slot_ff] <= 1'b1;
         end
      end
   end

   // Checks on the sequencer and match state.
`include "site_ban_substring_match_macros.svh"

   `SBSM_CHECK_NOW(a_result_from_hold, $rose(rsp_valid_ff), $past(state_ff == ST_HOLD))
   `SBSM_CHECK_NOW(a_proc_in_scan, proc_valid_ff, (state_ff == ST_SCAN) || (state_ff == ST_TAIL))
   `SBSM_CHECK_NEXT(a_tail_exit, state_ff == ST_TAIL, (state_ff == ST_IDLE) || (state_ff == ST_HOLD))
   `SBSM_CHECK_NOW(a_hits_cleared, (state_ff == ST_HOLD), hit_ff == '0)

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for site_ban_substring_match: directed table, then random traffic.
// Needs sbsm_pkg and the site_ban_substring_match RTL; the expected levels come from a
// ban-table predictor kept inside this file.
`timescale 1ns / 1ps

module tb;
   import sbsm_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int ITEM_GOAL = 1750;
   localparam int HOLD_CYCLES = 400;
   localparam int PRESSURE_AT = 700;
   localparam int DRAIN_CYCLES = 60;
   localparam longint LIMIT_NS = 64'd16_000_000;
   localparam int LEN_FIELD_MAX = (1 << LENF_W) - 1;

   // Opcode 3 has no meaning; the block must drop it.
   localparam bit [CMD_W-1:0] CMD_IGNORED = 2'd3;

   // One request transfer, one field per port.
   typedef struct packed {
      bit [CMD_W-1:0]   cmd;
      bit [SLOTF_W-1:0] slot;
      bit [POSF_W-1:0]  pos;
      bit [7:0]         data;
      bit [LENF_W-1:0]  len;
      bit [LVL_W-1:0]   lvl;
      bit               last;
   } table_cmd_type;

   // A directed row; known marks a level typed in by hand.
   typedef struct packed {
      table_cmd_type  item;
      bit             known;
      bit [LVL_W-1:0] level;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_cmd = '0;
   logic [SLOTF_W-1:0]   req_slot = '0;
   logic [POSF_W-1:0]    req_position = '0;
   logic [7:0]           req_data_byte = '0;
   logic [LENF_W-1:0]    req_pattern_length = '0;
   logic [LVL_W-1:0]     req_ban_level = '0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [LVL_W-1:0]     rsp_host_ban_level;

   // Predicted ban table and match state.
   bit [7:0]             pat_mem [SLOT_COUNT][PATTERN_MAX];
   bit                   wrote [SLOT_COUNT][PATTERN_MAX];
   bit [LEN_W-1:0]       len_tab [SLOT_COUNT];
   bit [LVL_W-1:0]       lvl_tab [SLOT_COUNT];
   bit [PATTERN_MAX-1:0] run_vec [SLOT_COUNT];
   bit                   hit_tab [SLOT_COUNT];

   bit [LVL_W-1:0]       due_levels [$];
   plan_row_type         plan_rows [$];
   int                   mismatches = 0;
   int                   items_sent = 0;
   bit                   steady = 1'b0;
   bit                   hold_off_req = 1'b0;
   bit                   pressure_done = 1'b0;

   site_ban_substring_match i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_slot           (req_slot),
      .req_position       (req_position),
      .req_data_byte      (req_data_byte),
      .req_pattern_length (req_pattern_length),
      .req_ban_level      (req_ban_level),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_host_ban_level (rsp_host_ban_level)
   );

   always #HALF_PERIOD clock = ~clock;

   // Hard stop in case a transfer never completes.
   initial begin
      #(LIMIT_NS);
      $display("site_ban_substring_match regression: fail");
      $finish;
   end

   // ASCII upper case to lower case, nothing else touched.
   function automatic bit [7:0] lower_case(input bit [7:0] b);
      return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
   endfunction

   // Applies one accepted request to the predicted table. Returns 1 when the
   // request ends a hostname, with the highest level of the matching slots.
   function automatic bit advance_ban_table(input table_cmd_type it,
                                            output bit [LVL_W-1:0] level);
      bit [7:0]             c;
      bit [PATTERN_MAX-1:0] eq;
      int                   n;
      level = '0;
      case (it.cmd)
         CMD_WRITE_BYTE: begin
            pat_mem[it.slot][it.pos] = lower_case(it.data);
            wrote[it.slot][it.pos] = 1'b1;
         end
         CMD_SET_SLOT: begin
            n = (it.len > PATTERN_MAX) ? PATTERN_MAX : int'(it.len);
            len_tab[it.slot] = LEN_W'(n);
            lvl_tab[it.slot] = it.lvl;
            run_vec[it.slot] = '0;
            hit_tab[it.slot] = 1'b0;
         end
         CMD_HOST_BYTE: begin
            c = lower_case(it.data);
            // Shift-and step for every slot in use.
            for (int s = 0; s < SLOT_COUNT; s++) begin
               n = len_tab[s];
               if (n != 0) begin
                  eq = '0;
                  for (int j = 0; j < n; j++) begin
                     if (pat_mem[s][j] == c) begin
                        eq[j] = 1'b1;
                     end
                  end
                  run_vec[s] = {run_vec[s][PATTERN_MAX-2:0], 1'b1} & eq;
                  if (run_vec[s][n-1]) begin
                     hit_tab[s] = 1'b1;
                  end
               end
            end
            if (it.last) begin
               for (int s = 0; s < SLOT_COUNT; s++) begin
                  if (len_tab[s] != 0 && hit_tab[s] && lvl_tab[s] > level) begin
                     level = lvl_tab[s];
                  end
                  run_vec[s] = '0;
                  hit_tab[s] = 1'b0;
               end
               return 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Idle length for either side: mostly none or short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Mostly a few letters in either case so that patterns hit; sometimes any byte.
   function automatic bit [7:0] pick_char();
      bit [7:0] c;
      if ($urandom_range(0, 99) < 75) begin
         c = 8'h61 + 8'($urandom_range(0, 3));
         if ($urandom_range(0, 1) == 1) begin
            c = c ^ 8'h20;
         end
      end else begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // Number of pattern bytes written without a hole, counting from position 0.
   function automatic int prefix_len(input int s);
      int p;
      p = 0;
      while (p < PATTERN_MAX && wrote[s][p]) begin
         p++;
      end
      return p;
   endfunction

   // Every field random; callers override what matters.
   function automatic table_cmd_type any_fields();
      table_cmd_type it;
      it.cmd  = CMD_W'($urandom_range(0, 3));
      it.slot = SLOTF_W'($urandom_range(0, SLOT_COUNT - 1));
      it.pos  = POSF_W'($urandom_range(0, PATTERN_MAX - 1));
      it.data = 8'($urandom_range(0, 255));
      it.len  = LENF_W'($urandom_range(0, LEN_FIELD_MAX));
      it.lvl  = LVL_W'($urandom_range(0, 3));
      it.last = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   // Drives one request and waits for its transfer, then updates the prediction.
   task automatic offer(input table_cmd_type it, input bit known,
                        input bit [LVL_W-1:0] typed);
      int             g;
      bit [LVL_W-1:0] level;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= it.cmd;
      req_slot           <= it.slot;
      req_position       <= it.pos;
      req_data_byte      <= it.data;
      req_pattern_length <= it.len;
      req_ban_level      <= it.lvl;
      req_last_byte      <= it.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (advance_ban_table(it, level)) begin
         due_levels.push_back(known ? typed : level);
      end
      if (it.cmd != CMD_IGNORED) begin
         items_sent++;
      end
   endtask

   task automatic add_row(input bit [CMD_W-1:0] cmd, input int slot, input int pos,
                          input bit [7:0] data, input int len, input int lvl,
                          input bit last, input bit known, input int level);
      plan_row_type row;
      row.item.cmd  = cmd;
      row.item.slot = SLOTF_W'(slot);
      row.item.pos  = POSF_W'(pos);
      row.item.data = data;
      row.item.len  = LENF_W'(len);
      row.item.lvl  = LVL_W'(lvl);
      row.item.last = last;
      row.known     = known;
      row.level     = LVL_W'(level);
      plan_rows.push_back(row);
   endtask

   // A slot setting with a length that never reaches past the written bytes.
   function automatic table_cmd_type legal_set(input table_cmd_type it);
      int p;
      p = prefix_len(it.slot);
      if (((it.len > PATTERN_MAX) ? PATTERN_MAX : int'(it.len)) > p) begin
         it.len = LENF_W'($urandom_range(0, p));
      end
      return it;
   endfunction

   // Writes a fresh pattern into a slot and bans it, or lifts a ban.
   task automatic program_slot();
      table_cmd_type it;
      int            s;
      int            n;
      int            r;
      s = $urandom_range(0, SLOT_COUNT - 1);
      r = $urandom_range(0, 99);
      if (r < 12) begin
         it = any_fields();
         it.cmd = CMD_SET_SLOT;
         it.slot = SLOTF_W'(s);
         it.len = '0;
         offer(it, 1'b0, '0);
      end else begin
         if (r < 55) n = $urandom_range(1, 3);
         else if (r < 80) n = $urandom_range(4, 8);
         else if (r < 92) n = $urandom_range(9, PATTERN_MAX - 1);
         else n = PATTERN_MAX;
         for (int j = 0; j < n; j++) begin
            it = any_fields();
            it.cmd = CMD_WRITE_BYTE;
            it.slot = SLOTF_W'(s);
            it.pos = POSF_W'(j);
            it.data = pick_char();
            offer(it, 1'b0, '0);
         end
         // Full-length patterns also carry oversized length fields.
         it = any_fields();
         it.cmd = CMD_SET_SLOT;
         it.slot = SLOTF_W'(s);
         it.len = (n == PATTERN_MAX) ? LENF_W'($urandom_range(PATTERN_MAX, LEN_FIELD_MAX))
                                     : LENF_W'(n);
         offer(it, 1'b0, '0);
      end
   endtask

   // Any single request, kept within the contract for slot settings.
   task automatic random_noise();
      table_cmd_type it;
      it = any_fields();
      if (it.cmd == CMD_SET_SLOT) begin
         it = legal_set(it);
      end
      offer(it, 1'b0, '0);
   endtask

   // Streams one hostname, often with a banned pattern buried in it.
   task automatic stream_host();
      bit [7:0]      bytes [$];
      bit [7:0]      c;
      table_cmd_type it;
      int            s;
      s = $urandom_range(0, SLOT_COUNT - 1);
      repeat ($urandom_range(0, 4)) bytes.push_back(pick_char());
      if (len_tab[s] != 0 && $urandom_range(0, 99) < 65) begin
         for (int j = 0; j < len_tab[s]; j++) begin
            c = pat_mem[s][j];
            if (c inside {[8'h61:8'h7A]} && $urandom_range(0, 1) == 1) begin
               c = c ^ 8'h20;
            end
            bytes.push_back(c);
         end
      end
      repeat ($urandom_range(0, 4)) bytes.push_back(pick_char());
      if (bytes.size() == 0) begin
         bytes.push_back(pick_char());
      end
      for (int i = 0; i < bytes.size(); i++) begin
         // Now and then the table changes while the hostname is in flight.
         if (i < bytes.size() - 1 && $urandom_range(0, 99) < 6) begin
            random_noise();
         end
         it = any_fields();
         it.cmd = CMD_HOST_BYTE;
         it.data = bytes[i];
         it.last = (i == bytes.size() - 1);
         offer(it, 1'b0, '0);
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : receiver
      int g;
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            g = pick_gap();
            if (g > 0) begin
               rsp_ready <= 1'b0;
               repeat (g) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Compare every result transfer with the oldest pending level.
   always @(posedge clock) begin : check_results
      bit [LVL_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_levels.size() == 0) begin
            log_mismatch($sformatf("result %b with no hostname pending", rsp_host_ban_level));
         end else begin
            want = due_levels.pop_front();
            if (rsp_host_ban_level !== want) begin
               log_mismatch($sformatf("host_ban_level expected %0d, got %b",
                                      want, rsp_host_ban_level));
            end
         end
      end
   end

   initial begin : stimulus
      table_cmd_type it;
      int            r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: cmd, slot, pos, byte, length, level, last, known, level.
      // Nothing is banned straight after reset.
      add_row(CMD_HOST_BYTE, 0, 0, "x", 0, 0, 1, 1, 0);
      // Unused opcode with every field at its top value is dropped.
      add_row(CMD_IGNORED, 15, 31, 8'hFF, LEN_FIELD_MAX, 3, 1, 0, 0);
      // Upper case pattern byte is folded; last on table commands means nothing.
      add_row(CMD_WRITE_BYTE, 0, 0, "A", 0, 0, 0, 0, 0);
      add_row(CMD_WRITE_BYTE, 0, 1, "b", 0, 0, 1, 0, 0);
      add_row(CMD_SET_SLOT, 0, 0, 8'h00, 2, 3, 1, 0, 0);
      add_row(CMD_HOST_BYTE, 0, 0, "x", 0, 0, 0, 0, 0);
      add_row(CMD_HOST_BYTE, 0, 0, "a", 0, 0, 0, 0, 0);
      add_row(CMD_HOST_BYTE, 0, 0, "B", 0, 0, 1, 1, 3);
      // Zero and all-ones bytes are ordinary pattern bytes in the top slot.
      add_row(CMD_WRITE_BYTE, 15, 0, 8'h00, 0, 0, 0, 0, 0);
      add_row(CMD_WRITE_BYTE, 15, 1, 8'hFF, 0, 0, 0, 0, 0);
      add_row(CMD_SET_SLOT, 15, 0, 8'h00, 2, 1, 0, 0, 0);
      add_row(CMD_HOST_BYTE, 0, 0, 8'h00, 0, 0, 0, 0, 0);
      add_row(CMD_HOST_BYTE, 0, 0, 8'hFF, 0, 0, 1, 0, 0);
      // Reprogramming a slot mid-hostname drops its partial match.
      add_row(CMD_HOST_BYTE, 0, 0, "a", 0, 0, 0, 0, 0);
      add_row(CMD_SET_SLOT, 0, 0, 8'h00, 2, 2, 0, 0, 0);
      add_row(CMD_HOST_BYTE, 0, 0, "b", 0, 0, 1, 0, 0);
      // Rewriting a pattern byte mid-hostname affects only later bytes.
      add_row(CMD_HOST_BYTE, 0, 0, "a", 0, 0, 0, 0, 0);
      add_row(CMD_WRITE_BYTE, 0, 1, "Z", 0, 0, 0, 0, 0);
      add_row(CMD_HOST_BYTE, 0, 0, "z", 0, 0, 1, 0, 0);
      // Bytes just outside A-Z are not folded; last position is writable.
      add_row(CMD_WRITE_BYTE, 7, 31, "@", 0, 0, 0, 0, 0);
      add_row(CMD_WRITE_BYTE, 7, 0, "[", 0, 0, 0, 0, 0);
      add_row(CMD_SET_SLOT, 7, 0, 8'h00, 1, 1, 0, 0, 0);
      // Lifting a ban with length zero ignores the level given.
      add_row(CMD_SET_SLOT, 0, 0, 8'h00, 0, 3, 0, 0, 0);
      add_row(CMD_HOST_BYTE, 0, 0, "@", 0, 0, 0, 0, 0);
      add_row(CMD_HOST_BYTE, 0, 0, "[", 0, 0, 1, 0, 0);

      foreach (plan_rows[i]) begin
         offer(plan_rows[i].item, plan_rows[i].known, plan_rows[i].level);
      end

      // Random traffic: mostly bans and hostnames, some noise.
      while (items_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 99) < 4) begin
            steady = !steady;
         end
         if (!pressure_done && items_sent >= PRESSURE_AT) begin
            // Back-to-back hostnames while the result side holds off.
            pressure_done = 1'b1;
            hold_off_req = 1'b1;
            repeat (24) begin
               it = any_fields();
               it.cmd = CMD_HOST_BYTE;
               it.data = pick_char();
               it.last = 1'b1;
               offer(it, 1'b0, '0);
            end
         end
         r = $urandom_range(0, 99);
         if (r < 30) begin
            program_slot();
         end else if (r < 85) begin
            stream_host();
         end else begin
            random_noise();
         end
      end
      req_valid <= 1'b0;

      while (due_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("site_ban_substring_match regression: pass");
      end else begin
         $display("site_ban_substring_match regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/sbsm_pkg.sv
hdl/site_ban_substring_match.sv
dv/tb.sv
